// ----- hdl/lppd_pkg.sv -----
// shared types and constants for the length-prefixed packet deframer
// no dependencies; imported by every module of the block
package lppd_pkg;

  // header layout: type, version, 4 id bytes, 4 length bytes
  localparam int unsigned HDR_BYTES = 10;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned MAX_LEN_W = 17;

  localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_VERSION = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ID0     = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ID3     = POS_W'(5);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HDR_BYTES);

  // 64*1024 minus header bytes
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(64 * 1024 - HDR_BYTES);

  // tdata width of the result beat: type, version, id, length, data byte
  localparam int unsigned RES_DATA_W = 8 + 8 + 32 + 32 + 8;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  msg_type;
    logic [7:0]  msg_version;
    logic [31:0] msg_id;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

endpackage

// ----- hdl/length_prefixed_packet_deframer_core.sv -----
// a result beat is registered and appears in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle; the single result register stalls input only
//   while it is full and the downstream side is not ready
// reset: synchronous rst clears the header position, counters and output valid,
//   and sets the max payload length to 65526
module length_prefixed_packet_deframer_core
  import lppd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [MAX_LEN_W-1:0]  cfg_wdata,     // max_payload_len
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,       // rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // msg_type, msg_version, msg_id, payload_length, data_byte
  output logic [RES_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,       // result_kind
  output logic                  m_tlast        // last
);

  logic    in_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    out_full;

  // accept while the result register is empty or draining
  assign s_tready = !out_full || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  lppd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .rx_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  lppd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (in_fire && res_valid),
    .load_res (res),
    .take     (m_tready),
    .full     (out_full),
    .held_res (out_res)
  );

  // output beat packing
  assign m_tvalid = out_full;
  assign m_tuser  = out_res.kind;
  assign m_tlast  = out_res.last;
  assign m_tdata  = {out_res.data_byte, out_res.payload_length, out_res.msg_id,
                     out_res.msg_version, out_res.msg_type};

endmodule

// ----- hdl/lppd_parser.sv -----
// header parser and payload counter: one received byte per beat
// depends on lppd_pkg
module lppd_parser
  import lppd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [MAX_LEN_W-1:0] cfg_wdata,
  input  logic                 in_fire,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  output result_t              res
);

  logic [MAX_LEN_W-1:0] max_len;
  logic [POS_W-1:0]     header_position, header_position_next;
  logic [7:0]           held_type, held_type_next;
  logic [7:0]           held_version, held_version_next;
  logic [31:0]          held_id, held_id_next;
  logic [31:0]          held_length, held_length_next;
  logic [31:0]          bytes_remaining, bytes_remaining_next;
  logic                 discarding, discarding_next;

  logic [POS_W-1:0]     pos_eff;
  logic                 disc_eff;
  logic                 pay_last;
  logic                 oversize;

  // max length register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  // next state and result for the byte on the input
  always_comb begin
    pos_eff  = header_position;
    disc_eff = discarding;
    if (header_position >= POS_PAYLOAD && bytes_remaining == 32'd0) begin
      pos_eff  = POS_TYPE;
      disc_eff = 1'b0;
    end

    header_position_next = pos_eff;
    held_type_next       = held_type;
    held_version_next    = held_version;
    held_id_next         = held_id;
    held_length_next     = held_length;
    bytes_remaining_next = bytes_remaining;
    discarding_next      = disc_eff;
    pay_last             = (bytes_remaining == 32'd1);
    oversize             = 1'b0;
    res_valid            = 1'b0;
    res.kind             = KIND_HEADER;
    res.data_byte        = 8'd0;
    res.last             = 1'b0;

    if (pos_eff >= POS_PAYLOAD) begin
      // payload byte: count down, pass through unless dropping
      bytes_remaining_next = bytes_remaining - 32'd1;
      if (pay_last) begin
        header_position_next = POS_TYPE;
        discarding_next      = 1'b0;
      end
      if (!disc_eff) begin
        res_valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = rx_byte;
        res.last      = pay_last;
      end
    end else begin
      // header byte: collect field
      unique case (pos_eff)
        POS_TYPE: begin
          held_type_next    = rx_byte;
          held_version_next = 8'd0;
          held_id_next      = 32'd0;
          held_length_next  = 32'd0;
        end
        POS_VERSION: begin
          held_version_next = rx_byte;
        end
        default: begin
          if (pos_eff >= POS_ID0 && pos_eff <= POS_ID3) begin
            held_id_next = {held_id[23:0], rx_byte};
          end else begin
            held_length_next = {held_length[23:0], rx_byte};
          end
        end
      endcase
      header_position_next = pos_eff + POS_W'(1);

      // header complete: check length
      if (header_position_next == POS_PAYLOAD) begin
        bytes_remaining_next = held_length_next;
        oversize             = held_length_next > {{(32-MAX_LEN_W){1'b0}}, max_len};
        res_valid            = 1'b1;
        if (oversize) begin
          discarding_next = 1'b1;
          res.kind        = KIND_ERROR;
          res.last        = 1'b1;
        end else begin
          discarding_next = 1'b0;
          res.kind        = KIND_HEADER;
          if (held_length_next == 32'd0) begin
            header_position_next = POS_TYPE;
            res.last             = 1'b1;
          end
        end
      end
    end

    res.msg_type       = held_type_next;
    res.msg_version    = held_version_next;
    res.msg_id         = held_id_next;
    res.payload_length = held_length_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= POS_TYPE;
      bytes_remaining <= 32'd0;
      discarding      <= 1'b0;
    end else if (in_fire) begin
      header_position <= header_position_next;
      bytes_remaining <= bytes_remaining_next;
      discarding      <= discarding_next;
    end
  end

  // collected header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      held_type    <= 8'd0;
      held_version <= 8'd0;
      held_id      <= 32'd0;
      held_length  <= 32'd0;
    end else if (in_fire) begin
      held_type    <= held_type_next;
      held_version <= held_version_next;
      held_id      <= held_id_next;
      held_length  <= held_length_next;
    end
  end

  // position never runs past the payload phase
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    header_position <= POS_PAYLOAD)
    else $error("header position out of range");

  // payload phase always has bytes left to count
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    header_position == POS_PAYLOAD |-> bytes_remaining != 32'd0)
    else $error("payload phase with nothing remaining");

  // dropping only happens in the payload phase
  a_disc_phase: assert property (@(posedge clk) disable iff (rst)
    discarding |-> header_position == POS_PAYLOAD)
    else $error("discarding outside payload phase");

endmodule

// ----- hdl/lppd_out_reg.sv -----
// result register between parser and output stream
// depends on lppd_pkg
module lppd_out_reg
  import lppd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  input  logic    take,
  output logic    full,
  output result_t held_res
);

  logic full_next;

  // occupancy: a new load wins over a take of the old beat
  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      held_res <= load_res;
    end
  end

endmodule

// ----- verif/lppd_stream_checker.sv -----
// stream checker for the length-prefixed packet deframer: tracks the header parse and
// payload count on its own, predicts each result beat and compares it with the output
// depends on lppd_pkg for the result layout, the header positions and the kind codes
module lppd_stream_checker
  import lppd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [MAX_LEN_W-1:0]  cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [RES_DATA_W-1:0] m_tdata,
  input  logic [1:0]            m_tuser,
  input  logic                  m_tlast,
  output int                    pending,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // own copy of the parser state and the length limit
  logic [POS_W-1:0]     hdr_pos;
  logic [7:0]           cur_type;
  logic [7:0]           cur_version;
  logic [31:0]          cur_id;
  logic [31:0]          cur_len;
  logic [31:0]          remaining;
  logic                 dropping;
  logic [MAX_LEN_W-1:0] max_len;

  result_t expected_beats[$];

  function automatic result_t packet_beat(kind_t k, logic [7:0] d, logic l);
    result_t r;
    r.kind           = k;
    r.msg_type       = cur_type;
    r.msg_version    = cur_version;
    r.msg_id         = cur_id;
    r.payload_length = cur_len;
    r.data_byte      = d;
    r.last           = l;
    return r;
  endfunction

  // advance the parser by one received byte, queue the beat it causes if any
  task automatic deframe_byte(input logic [7:0] b);
    result_t r;
    bit      emit;
    emit = 1'b0;
    // payload phase with nothing left cannot happen, but restart the header if it does
    if (hdr_pos >= POS_PAYLOAD && remaining == 32'd0) begin
      hdr_pos  = POS_TYPE;
      dropping = 1'b0;
    end
    if (hdr_pos >= POS_PAYLOAD) begin
      remaining = remaining - 32'd1;
      if (remaining == 32'd0) hdr_pos = POS_TYPE;
      if (dropping) begin
        // oversize payload is swallowed silently
        if (remaining == 32'd0) dropping = 1'b0;
      end else begin
        r    = packet_beat(KIND_PAYLOAD, b, remaining == 32'd0);
        emit = 1'b1;
      end
    end else begin
      case (hdr_pos)
        POS_TYPE: begin
          cur_type    = b;
          cur_version = 8'd0;
          cur_id      = 32'd0;
          cur_len     = 32'd0;
        end
        POS_VERSION: cur_version = b;
        default: begin
          if (hdr_pos <= POS_ID3) cur_id = {cur_id[23:0], b};
          else cur_len = {cur_len[23:0], b};
        end
      endcase
      hdr_pos = hdr_pos + POS_W'(1);
      // header complete
      if (hdr_pos == POS_PAYLOAD) begin
        remaining = cur_len;
        emit      = 1'b1;
        if (cur_len > 32'(max_len)) begin
          dropping = 1'b1;
          r        = packet_beat(KIND_ERROR, 8'd0, 1'b1);
        end else begin
          dropping = 1'b0;
          if (cur_len == 32'd0) begin
            hdr_pos = POS_TYPE;
            r       = packet_beat(KIND_HEADER, 8'd0, 1'b1);
          end else begin
            r = packet_beat(KIND_HEADER, 8'd0, 1'b0);
          end
        end
      end
    end
    if (emit) expected_beats.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t ns: mismatch in %s, expected 0x%0h, got 0x%0h", $time, name, want, seen);
      fail_count++;
    end
  endtask

  // compare the output beat first, then fold in the input byte of the same edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      hdr_pos     = POS_TYPE;
      cur_type    = 8'd0;
      cur_version = 8'd0;
      cur_id      = 32'd0;
      cur_len     = 32'd0;
      remaining   = 32'd0;
      dropping    = 1'b0;
      max_len     = MAX_LEN_RESET;
      fail_count  = 0;
      expected_beats.delete();
    end else begin
      if (cfg_we) max_len = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, got kind %0d data 0x%0h",
                   $time, m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(m_tuser));
          check_field("msg_type", 32'(want.msg_type), 32'(m_tdata[7:0]));
          check_field("msg_version", 32'(want.msg_version), 32'(m_tdata[15:8]));
          check_field("msg_id", want.msg_id, m_tdata[47:16]);
          check_field("payload_length", want.payload_length, m_tdata[79:48]);
          check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[87:80]));
          check_field("last", 32'(want.last), 32'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
    end
    pending = expected_beats.size();
  end

endmodule

// ----- verif/length_prefixed_packet_deframer_core_tb.sv -----
// top of the deframer testbench: clock, reset, packet stimulus with bursty input and
// a stalling output side, length limit changes between phases, and the final verdict
// depends on lppd_pkg, length_prefixed_packet_deframer_core and lppd_stream_checker
module length_prefixed_packet_deframer_core_tb;
  import lppd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_ONE_IN_N,
    READY_BLOCKED
  } ready_mode_t;

  localparam int PHASE_BYTES = 170;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [MAX_LEN_W-1:0]  cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'd0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [RES_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  int                    pending;
  int                    fail_count;
  logic                  byte_taken = 1'b0;
  int                    burst_left = 0;
  int                    phase_bytes = 0;

  ready_mode_t           rmode = READY_ALWAYS;
  int                    rmode_left = 0;
  int                    rmode_n = 1;
  int                    rmode_cnt = 0;

  always #6 clk = ~clk;

  length_prefixed_packet_deframer_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  lppd_stream_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // input beat accepted at the last rising edge
  always @(posedge clk) begin
    byte_taken <= s_tvalid && s_tready;
  end

  // output side stalls in modes of random length
  always @(negedge clk) begin
    if (rmode_left == 0) begin
      rmode      = ready_mode_t'($urandom_range(0, 3));
      rmode_left = (rmode == READY_BLOCKED) ? $urandom_range(1, 16) : $urandom_range(20, 200);
      rmode_n    = $urandom_range(2, 5);
      rmode_cnt  = 0;
    end
    rmode_left--;
    rmode_cnt++;
    case (rmode)
      READY_ALWAYS:   m_tready <= 1'b1;
      READY_COIN:     m_tready <= 1'($urandom);
      READY_ONE_IN_N: m_tready <= (rmode_cnt % rmode_n) == 0;
      default:        m_tready <= 1'b0;
    endcase
  end

  // one input beat, sent in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(negedge clk); while (!byte_taken);
    burst_left--;
    phase_bytes++;
  endtask

  task automatic send_packet(input logic [7:0] ptype, input logic [7:0] pver,
                             input logic [31:0] pid, input logic [31:0] plen);
    send_byte(ptype);
    send_byte(pver);
    for (int i = 3; i >= 0; i--) send_byte(pid[8*i +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(plen[8*i +: 8]);
    for (int unsigned n = 0; n < plen; n++) send_byte(8'($urandom));
  endtask

  // stop sending and let every expected beat come out, plus the block's latency
  task automatic drain_results;
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [MAX_LEN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // header bytes lean toward all-zeros and all-ones
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // lengths around the limit, zero, and mostly short payloads
  function automatic logic [31:0] pick_length(input int unsigned m);
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return (m <= 60) ? m : $urandom_range(25, 60);
      2:       return (m < 60) ? m + 1 : $urandom_range(1, 60);
      3:       return $urandom_range(25, 120);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  initial begin
    #5_000_000;
    $display("FAIL length_prefixed_packet_deframer_core");
    $finish;
  end

  initial begin
    int unsigned max_settings[8];
    int unsigned lim;
    max_settings = '{0, 1, 65536, 7, 131071, $urandom_range(2, 40), 65526,
                     $urandom_range(0, 131071)};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limit: zero length with extreme header fields, then a one-byte payload
    send_packet(8'hff, 8'h00, 32'hffff_ffff, 32'd0);
    send_packet(8'h00, 8'hff, 32'h0000_0000, 32'd1);
    drain_results();

    foreach (max_settings[p]) begin
      lim = max_settings[p];
      write_max_len(MAX_LEN_W'(lim));
      phase_bytes = 0;
      // zero limit: any nonzero length is an oversize packet that gets discarded
      if (lim == 0) send_packet(8'h5a, 8'h01, 32'h0102_0304, 32'd1);
      while (phase_bytes < PHASE_BYTES) begin
        send_packet(pick_byte(), pick_byte(),
                    {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                    pick_length(lim));
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("PASS length_prefixed_packet_deframer_core");
    end else begin
      $display("FAIL length_prefixed_packet_deframer_core");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lppd_pkg.sv
hdl/lppd_parser.sv
hdl/lppd_out_reg.sv
hdl/length_prefixed_packet_deframer_core.sv
verif/lppd_stream_checker.sv
verif/length_prefixed_packet_deframer_core_tb.sv
